### rtl/scf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scf_pkg
// Types, constants and helper functions shared by the SLIP/CRC16 frame
// encoder modules.
// ----------------------------------------------------------------------------
package scf_pkg;

	localparam int unsigned SLOTS = 8;

	// register indexes on the configuration port
	localparam logic [2:0] REG_END_CODE     = 3'd0;
	localparam logic [2:0] REG_ESCAPE_CODE  = 3'd1;
	localparam logic [2:0] REG_ESC_END_CODE = 3'd2;
	localparam logic [2:0] REG_ESC_ESC_CODE = 3'd3;

	localparam logic [7:0] END_CODE_RST     = 8'hC0;
	localparam logic [7:0] ESCAPE_CODE_RST  = 8'hDB;
	localparam logic [7:0] ESC_END_CODE_RST = 8'hDC;
	localparam logic [7:0] ESC_ESC_CODE_RST = 8'hDD;

	typedef struct packed {
		logic [7:0] end_code;
		logic [7:0] escape_code;
		logic [7:0] escaped_end_code;
		logic [7:0] escaped_escape_code;
	} scf_codes_t;

	// up to eight line bytes, slot 0 in the low byte
	typedef struct packed {
		logic [8*SLOTS-1:0] bytes;
		logic [2:0]         last_idx;
		logic               fend;
	} scf_list_t;

	typedef struct packed {
		logic [15:0] pair;
		logic [1:0]  len;
	} scf_esc_t;

	function automatic scf_esc_t scf_escape(input logic [7:0] b, input scf_codes_t c);
		scf_esc_t r;
		// delimiter test comes first
		if (b == c.end_code) begin
			r.pair = {c.escaped_end_code, c.escape_code};
			r.len  = 2'd2;
		end else if (b == c.escape_code) begin
			r.pair = {c.escaped_escape_code, c.escape_code};
			r.len  = 2'd2;
		end else begin
			r.pair = {8'h00, b};
			r.len  = 2'd1;
		end
		return r;
	endfunction

	// CRC-16/XMODEM, one byte
	function automatic logic [15:0] scf_crc_update(input logic [15:0] crc,
	                                               input logic [7:0] b);
		logic [7:0] t;
		t = crc[15:8] ^ b;
		t = t ^ (t >> 4);
		return {crc[7:0], 8'h00} ^ {t[3:0], 12'h000} ^ {3'b000, t, 5'b00000} ^ {8'h00, t};
	endfunction

endpackage
`default_nettype wire

### rtl/scf_expand.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scf_expand
// Builds the full list of line bytes caused by one packet byte, and the
// CRC and frame state that follow it.
// ----------------------------------------------------------------------------
module scf_expand
	import scf_pkg::*;
(
	input  wire scf_codes_t  codes,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_byte,
	input  wire logic [15:0] crc,
	input  wire logic        in_frame,
	output scf_list_t        list,
	output logic [15:0]      crc_next,
	output logic             inside_next
);

	logic [15:0]        crc_upd;
	scf_esc_t           e_data;
	scf_esc_t           e_hi;
	scf_esc_t           e_lo;
	logic [8*SLOTS-1:0] vec;
	logic [3:0]         ptr;

	assign crc_upd = scf_crc_update(crc, data_byte);
	assign e_data  = scf_escape(data_byte, codes);
	assign e_hi    = scf_escape(crc_upd[15:8], codes);
	assign e_lo    = scf_escape(crc_upd[7:0], codes);

	always_comb begin
		vec = '0;
		ptr = 4'd0;
		if (!in_frame) begin
			vec[7:0] = codes.end_code;
			ptr      = 4'd1;
		end
		vec = vec | ((8*SLOTS)'(e_data.pair) << {ptr, 3'b000});
		ptr = ptr + 4'(e_data.len);
		if (last_byte) begin
			vec = vec | ((8*SLOTS)'(e_hi.pair) << {ptr, 3'b000});
			ptr = ptr + 4'(e_hi.len);
			vec = vec | ((8*SLOTS)'(e_lo.pair) << {ptr, 3'b000});
			ptr = ptr + 4'(e_lo.len);
			vec = vec | ((8*SLOTS)'(codes.end_code) << {ptr, 3'b000});
			ptr = ptr + 4'd1;
		end
		list.bytes    = vec;
		list.last_idx = 3'(ptr - 4'd1);
		list.fend     = last_byte;
	end

	assign crc_next    = last_byte ? 16'h0000 : crc_upd;
	assign inside_next = !last_byte;

endmodule
`default_nettype wire

### rtl/scf_emit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scf_emit
// Holds one expanded byte list and sends it out one line byte per
// transaction. Takes the next list in the cycle the last byte leaves.
// ----------------------------------------------------------------------------
module scf_emit
	import scf_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       load,
	input  wire scf_list_t  list,
	output logic            ready,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      line_byte,
	output logic            run_end,
	output logic            frame_end
);

	scf_list_t  list_q;
	logic [2:0] idx_q;
	logic       busy_q;
	logic       done;

	assign done  = busy_q && !out_stall && run_end;
	assign ready = !busy_q || done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 3'd0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= 3'd0;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q && !out_stall) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			list_q <= list;
		end
	end

	assign out_valid = busy_q;
	assign line_byte = list_q.bytes[{idx_q, 3'b000} +: 8];
	assign run_end   = (idx_q == list_q.last_idx);
	assign frame_end = list_q.fend && run_end;

endmodule
`default_nettype wire

### rtl/slip_crc16_frame_encoder_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slip_crc16_frame_encoder_unit
// SLIP framer with a CRC-16/XMODEM trailer, one packet byte per transaction.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): data_byte plus last_byte on the final
// byte of a packet. Output channel (out_valid/out_stall): one line byte per
// transaction; run_end marks the last byte caused by an input, frame_end the
// closing delimiter.
// An accepted byte lands in the input register; from there its whole
// output list (opening delimiter, escaped byte, escaped CRC and closing
// delimiter as needed) is built and loaded into the output buffer once
// the buffer is ready; the first line byte is then offered from the buffer.
// Throughput is set by the output port: one line byte per cycle while
// out_stall is low; an input produces 1 to 8 line bytes, typically 1 or 2.
// The input register takes a new byte while the buffer still drains.
// A stall on the output holds the current line byte; the input register then
// fills and in_stall rises until the buffer frees up.
// Reset clears the CRC, closes any open frame and restores the standard
// SLIP codes. Write the code registers only while the block is idle.
// ----------------------------------------------------------------------------
module slip_crc16_frame_encoder_unit
	import scf_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_wr_en,
	input  wire logic [2:0] cfg_index,
	input  wire logic [7:0] cfg_data,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] data_byte,
	input  wire logic       last_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      line_byte,
	output logic            run_end,
	output logic            frame_end
);

	scf_codes_t  codes_q;
	logic [15:0] crc_q;
	logic        inside_q;

	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        last_s1;

	scf_list_t   list;
	logic [15:0] crc_next;
	logic        inside_next;
	logic        emit_ready;
	logic        take_s1;
	logic        in_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codes_q.end_code            <= END_CODE_RST;
			codes_q.escape_code         <= ESCAPE_CODE_RST;
			codes_q.escaped_end_code    <= ESC_END_CODE_RST;
			codes_q.escaped_escape_code <= ESC_ESC_CODE_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_END_CODE:     codes_q.end_code            <= cfg_data;
				REG_ESCAPE_CODE:  codes_q.escape_code         <= cfg_data;
				REG_ESC_END_CODE: codes_q.escaped_end_code    <= cfg_data;
				REG_ESC_ESC_CODE: codes_q.escaped_escape_code <= cfg_data;
				default: ;
			endcase
		end
	end

	assign take_s1  = valid_s1 && emit_ready;
	assign in_stall = valid_s1 && !emit_ready;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (take_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	scf_expand u_expand (
		.codes       (codes_q),
		.data_byte   (data_s1),
		.last_byte   (last_s1),
		.crc         (crc_q),
		.in_frame    (inside_q),
		.list        (list),
		.crc_next    (crc_next),
		.inside_next (inside_next)
	);

	// advance CRC and frame state when the list moves to the output buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q    <= 16'h0000;
			inside_q <= 1'b0;
		end else if (take_s1) begin
			crc_q    <= crc_next;
			inside_q <= inside_next;
		end
	end

	scf_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take_s1),
		.list      (list),
		.ready     (emit_ready),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.line_byte (line_byte),
		.run_end   (run_end),
		.frame_end (frame_end)
	);

	a_fend_is_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> run_end)
		else $error("frame_end without run_end");

	a_frame_closes: assert property (@(posedge clk) disable iff (!arst_n)
		take_s1 && last_s1 |=> !inside_q && crc_q == 16'h0000)
		else $error("frame state not cleared after last byte");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !run_end |=> out_valid)
		else $error("byte list dropped before its end");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid)
		else $error("input stalled with room to spare");

endmodule
`default_nettype wire
